[hdl/mibd_pkg.sv]
package mibd_pkg;

    localparam int WORD_BITS      = 32;
    localparam int TIME_BITS      = 32;
    localparam int BOUNCE_BITS    = 16;
    localparam int LINE_COUNT_DEF = 32;

    localparam logic [BOUNCE_BITS-1:0] BOUNCE_RESET = BOUNCE_BITS'(200);
    localparam logic [WORD_BITS-1:0]   STABLE_RESET = '1;

    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [BOUNCE_BITS-1:0] t_bounce;

    // per-tick control shared by all lanes
    typedef struct packed {
        logic    fire;
        t_time   now;
        t_bounce bounce;
    } t_tick;

endpackage

[hdl/mibd_ifs.sv]
interface mibd_cfg_if;
    logic                    valid;
    logic                    ready;
    mibd_pkg::t_bounce       bounce_time;

    modport source (output valid, output bounce_time, input ready);
    modport sink   (input valid, input bounce_time, output ready);
endinterface

interface mibd_in_if;
    logic                    valid;
    logic                    ready;
    mibd_pkg::t_word         sampled_bits;
    mibd_pkg::t_time         now_ms;
    logic                    queue_full;

    modport source (output valid, output sampled_bits, output now_ms, output queue_full,
                    input ready);
    modport sink   (input valid, input sampled_bits, input now_ms, input queue_full,
                    output ready);
endinterface

interface mibd_out_if;
    logic                    valid;
    logic                    ready;
    mibd_pkg::t_word         stable_bits;
    mibd_pkg::t_time         event_time;

    modport source (output valid, output stable_bits, output event_time, input ready);
    modport sink   (input valid, input stable_bits, input event_time, output ready);
endinterface

[hdl/mibd_lane.sv]
module mibd_lane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mibd_pkg::t_tick i_tick,
    input  logic            i_diff,
    output logic            o_hit
);
    import mibd_pkg::*;

    t_time r_last;
    t_time n_last;
    t_time w_elapsed;

    // wrap-around elapsed time since this line's last accepted change
    assign w_elapsed = i_tick.now - r_last;
    assign o_hit     = i_diff && (w_elapsed > TIME_BITS'(i_tick.bounce));

    always_comb begin
        n_last = r_last;
        if (i_tick.fire && o_hit) begin
            n_last = i_tick.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

[hdl/mibd_merge.sv]
module mibd_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mibd_pkg::t_tick i_tick,
    input  mibd_pkg::t_word i_hit,
    input  mibd_pkg::t_word i_sampled,
    input  logic            i_queue_full,
    output mibd_pkg::t_word o_stable,
    output logic            o_in_ready,
    mibd_out_if.source      o_out
);
    import mibd_pkg::*;

    t_word r_stable;
    t_word n_stable;
    logic  w_push;
    logic  w_pop;

    logic  r_out_valid;
    t_word r_out_word;
    t_time r_out_time;
    logic  r_skid_valid;
    t_word r_skid_word;
    t_time r_skid_time;

    assign n_stable   = (r_stable & ~i_hit) | (i_sampled & i_hit);
    assign w_push     = i_tick.fire && (|i_hit) && !i_queue_full;
    assign w_pop      = r_out_valid && o_out.ready;
    assign o_stable   = r_stable;
    assign o_in_ready = !r_skid_valid;

    assign o_out.valid       = r_out_valid;
    assign o_out.stable_bits = r_out_word;
    assign o_out.event_time  = r_out_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable     <= STABLE_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_stable <= n_stable;
            end
            // output word plus one skid word so a stalled receiver stops input only once both are full
            if (!r_out_valid || w_pop) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= w_push;
                end
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
                r_out_time <= r_skid_time;
            end else begin
                r_out_word <= n_stable;
                r_out_time <= i_tick.now;
            end
        end
        if (w_push) begin
            r_skid_word <= n_stable;
            r_skid_time <= i_tick.now;
        end
    end

    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_full_keeps_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.fire && i_queue_full) |=> (r_stable == $past(r_stable)))
        else $error("stable word changed while queue full");

    a_newest_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_skid_valid) |-> (r_out_word == r_stable))
        else $error("newest event word differs from stable word");

    a_skid_pushes_only_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid && r_out_valid && !o_out.ready && w_push) |=> r_skid_valid)
        else $error("event lost on stalled output");

endmodule

[hdl/multi_bit_input_debouncer_core.sv]
// time-lockout debouncer over up to 32 input lines
// channels: i_cfg writes bounce_time (16 bits, ms), always ready; i_in takes one word per
// millisecond tick (sampled_bits, now_ms, queue_full); o_out gives an event word
// (stable_bits, event_time) whenever at least one line's change is accepted and
// queue_full is low. a tick that accepts nothing, or arrives with queue_full set,
// gives no event (accepted lines still record now_ms as their change time).
// throughput: one tick per cycle while i_in.ready is high; every line below LINE_COUNT
// has its own lane with its own change-time register and compare, and all lanes settle
// in the cycle the tick is accepted; its event word is registered for o_out.
// stall: results sit in an output register backed by one skid register; i_in.ready
// drops only while the skid register is occupied, i.e. after the receiver has held
// off with two events pending, and rises again once it takes a word.
// reset (synchronous, active low): stable word all ones, change times zero,
// bounce_time 200, no pending events; no clearing pass is needed.
// lines at or above LINE_COUNT never change and keep their reset level.
module multi_bit_input_debouncer_core #(
    parameter int LINE_COUNT = mibd_pkg::LINE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mibd_cfg_if.sink   i_cfg,
    mibd_in_if.sink    i_in,
    mibd_out_if.source o_out
);
    import mibd_pkg::*;

    localparam int LANES = (LINE_COUNT < WORD_BITS) ? LINE_COUNT : WORD_BITS;

    t_bounce r_bounce;
    t_tick   w_tick;
    t_word   w_hit;
    t_word   w_stable;
    logic    w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce <= BOUNCE_RESET;
        end else if (i_cfg.valid) begin
            r_bounce <= i_cfg.bounce_time;
        end
    end

    assign w_tick.fire   = i_in.valid && w_in_ready;
    assign w_tick.now    = i_in.now_ms;
    assign w_tick.bounce = r_bounce;

    genvar g;
    generate
        for (g = 0; g < WORD_BITS; g++) begin : g_line
            if (g < LANES) begin : g_lane
                mibd_lane u_lane (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_tick  (w_tick),
                    .i_diff  (w_stable[g] ^ i_in.sampled_bits[g]),
                    .o_hit   (w_hit[g])
                );
            end else begin : g_idle
                assign w_hit[g] = 1'b0;
            end
        end
    endgenerate

    mibd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_hit        (w_hit),
        .i_sampled    (i_in.sampled_bits),
        .i_queue_full (i_in.queue_full),
        .o_stable     (w_stable),
        .o_in_ready   (w_in_ready),
        .o_out        (o_out)
    );

endmodule
